>>> rtl/ghn_pkg.sv
// ----------------------------------------------------------------------------
// ghn_pkg
// Shared types and constants of the gray-level histogram engine.
// ----------------------------------------------------------------------------
package ghn_pkg;

  localparam int PIX_W      = 8;
  localparam int MAX_BINS   = 2 ** PIX_W;
  localparam int OUT_W      = 24;
  localparam int HEIGHT_W   = 9;
  localparam int DIV_STEPS  = HEIGHT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_COUNT = 2'd1,
    OP_READ  = 2'd2
  } ghn_op_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } ghn_div_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ghn_div_stat_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [PIX_W-1:0] pixel_value;
    logic [PIX_W-1:0] bin_index;
  } ghn_req_t;

  typedef struct packed {
    logic [OUT_W-1:0]    bin_count;
    logic [OUT_W-1:0]    peak_count;
    logic [HEIGHT_W-1:0] bar_height;
  } ghn_rsp_t;

endpackage

>>> rtl/ghn_req_if.sv
// ----------------------------------------------------------------------------
// ghn_req_if
// Request channel: valid/ready handshake carrying one command.
// ----------------------------------------------------------------------------
interface ghn_req_if import ghn_pkg::*;;
  logic     valid;
  logic     ready;
  ghn_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ghn_rsp_if.sv
// ----------------------------------------------------------------------------
// ghn_rsp_if
// Response channel: valid/ready handshake carrying one bin read result.
// ----------------------------------------------------------------------------
interface ghn_rsp_if import ghn_pkg::*;;
  logic     valid;
  logic     ready;
  ghn_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ghn_bin_ram.sv
// ----------------------------------------------------------------------------
// ghn_bin_ram
// Bin count memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ghn_bin_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/ghn_divider.sv
// ----------------------------------------------------------------------------
// ghn_divider
// Restoring divider for bar height: count * 256 / peak, one bit per cycle.
// ----------------------------------------------------------------------------
module ghn_divider import ghn_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] num,
  input  logic [COUNT_BITS-1:0] den,
  input  logic                  take,
  output ghn_div_stat_t         stat,
  output logic [HEIGHT_W-1:0]   quot
);

  ghn_div_state_t        state, state_next;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [COUNT_BITS:0]   rem;
  logic [COUNT_BITS:0]   rsub;
  logic [COUNT_BITS-1:0] dvs;
  logic [HEIGHT_W-1:0]   q;
  logic                  den_zero;
  logic                  ge;

  assign ge   = rem >= {1'b0, dvs};
  assign rsub = ge ? rem - {1'b0, dvs} : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: if (start) state_next = DIV_RUN;
      DIV_RUN:  if (cnt == '0) state_next = DIV_DONE;
      DIV_DONE: if (take) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && start) begin
      rem      <= {1'b0, num};
      dvs      <= den;
      q        <= '0;
      cnt      <= DIV_CNT_W'(DIV_STEPS - 1);
      den_zero <= (den == '0);
    end else if (state == DIV_RUN) begin
      rem <= {rsub[COUNT_BITS-1:0], 1'b0};
      q   <= {q[HEIGHT_W-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

  assign stat.busy = (state != DIV_IDLE);
  assign stat.done = (state == DIV_DONE);
  assign quot      = den_zero ? '0 : q;

endmodule

>>> rtl/gray_histogram_normalizer_top.sv
// ----------------------------------------------------------------------------
// gray_histogram_normalizer_top
// Gray-level histogram with flash clear, running peak and bar height readout.
// ----------------------------------------------------------------------------
// Clear and count requests: one per cycle while no read is in progress; bins and
//   peak are updated from the registered s2 stage.
// Read requests: s2 stage, then the 9-step divider, then the response register; new
//   requests are held off until the result is loaded, longer while a response waits.
// Reset (synchronous): drops all bin valid flags, zeroes the peak and
//   empties the pipeline; the bin memory itself is not swept.
// ----------------------------------------------------------------------------
module gray_histogram_normalizer_top import ghn_pkg::*; #(
  parameter int NUM_BINS   = 256,
  parameter int COUNT_BITS = 24
) (
  input logic       clk,
  input logic       rst,
  ghn_req_if.sink   req,
  ghn_rsp_if.source rsp
);

  localparam int EFF_BINS = (NUM_BINS < MAX_BINS) ? NUM_BINS : MAX_BINS;
  localparam int ADDR_W   = $clog2(EFF_BINS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic                  accept;
  logic [PIX_W-1:0]      sel_idx;
  logic                  s2_valid;
  logic [1:0]            s2_op;
  logic [ADDR_W-1:0]     s2_addr;
  logic                  s2_hit;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  fwd_valid;
  logic [ADDR_W-1:0]     fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;
  logic [COUNT_BITS-1:0] raw;
  logic [COUNT_BITS-1:0] old;
  logic [COUNT_BITS-1:0] inc;
  logic [EFF_BINS-1:0]   valid_bits;
  logic [COUNT_BITS-1:0] peak;
  logic                  do_count;
  logic                  do_clear;
  logic                  do_read;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [COUNT_BITS-1:0] rd_peak;
  ghn_div_stat_t         div_stat;
  logic [HEIGHT_W-1:0]   quot;
  logic                  load;

  assign req.ready = !div_stat.busy && !(s2_valid && s2_op == OP_READ);
  assign accept    = req.valid && req.ready;
  assign sel_idx   = (req.data.op == OP_COUNT) ? req.data.pixel_value : req.data.bin_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_op   <= req.data.op;
      s2_addr <= sel_idx[ADDR_W-1:0];
      s2_hit  <= (32'(sel_idx) < 32'(EFF_BINS));
    end
  end

  ghn_bin_ram #(
    .DEPTH  (EFF_BINS),
    .ADDR_W (ADDR_W),
    .DATA_W (COUNT_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (do_count),
    .waddr (s2_addr),
    .wdata (inc),
    .re    (accept),
    .raddr (sel_idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  assign raw      = (fwd_valid && fwd_addr == s2_addr) ? fwd_data : rd_data;
  assign old      = (s2_hit && valid_bits[s2_addr]) ? raw : '0;
  assign inc      = (old == CNT_MAX) ? old : old + 1'b1;
  assign do_count = s2_valid && s2_op == OP_COUNT && s2_hit;
  assign do_clear = s2_valid && s2_op == OP_CLEAR;
  assign do_read  = s2_valid && s2_op == OP_READ;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      peak       <= '0;
      fwd_valid  <= 1'b0;
    end else if (do_clear) begin
      valid_bits <= '0;
      peak       <= '0;
      fwd_valid  <= 1'b0;
    end else begin
      fwd_valid <= do_count;
      if (do_count) begin
        valid_bits[s2_addr] <= 1'b1;
        if (inc > peak) begin
          peak <= inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_count) begin
      fwd_addr <= s2_addr;
      fwd_data <= inc;
    end
    if (do_read) begin
      rd_cnt  <= old;
      rd_peak <= peak;
    end
  end

  ghn_divider #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (do_read),
    .num   (old),
    .den   (peak),
    .take  (load),
    .stat  (div_stat),
    .quot  (quot)
  );

  assign load = div_stat.done && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.data.bin_count  <= OUT_W'(rd_cnt);
      rsp.data.peak_count <= OUT_W'(rd_peak);
      rsp.data.bar_height <= quot;
    end
  end

endmodule

>>> rtl/ghn_checker.sv
// ----------------------------------------------------------------------------
// ghn_checker
// Port-level checks of the histogram engine, bound to the top level.
// ----------------------------------------------------------------------------
module ghn_checker import ghn_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic [1:0]          req_op,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [OUT_W-1:0]    rsp_bin_count,
  input logic [OUT_W-1:0]    rsp_peak_count,
  input logic [HEIGHT_W-1:0] rsp_bar_height
);

  a_read_interlock: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_op == OP_READ |=> !req_ready)
    else $error("request taken right after a read");

  a_rst_no_rsp: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_full_bar: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_bar_height == HEIGHT_W'(MAX_BINS) |-> rsp_bin_count == rsp_peak_count)
    else $error("full bar height without bin at peak");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_count)
      && $stable(rsp_peak_count) && $stable(rsp_bar_height))
    else $error("stalled response changed");

endmodule

bind gray_histogram_normalizer_top ghn_checker u_ghn_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_op         (req.data.op),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_bin_count  (rsp.data.bin_count),
  .rsp_peak_count (rsp.data.peak_count),
  .rsp_bar_height (rsp.data.bar_height)
);

>>> tb/gray_histogram_normalizer_checker.sv
// ----------------------------------------------------------------------------
// gray_histogram_normalizer_checker
// Watches the request and response channels of the histogram engine. It keeps
// its own bins, live flags and running peak, predicts every bin read and
// compares each response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module gray_histogram_normalizer_checker import ghn_pkg::*; #(
  parameter int NUM_BINS   = 256,
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  ghn_req_if          req,
  ghn_rsp_if          rsp,
  output int unsigned mismatches,
  output int unsigned reads_checked,
  output int unsigned full_bin_hits,
  output int unsigned reads_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned COUNT_FULL   = (64'd1 << COUNT_BITS) - 1;
  localparam longint unsigned HEIGHT_SCALE = 256;
  localparam int              MAX_REPORTS  = 40;

  bit [COUNT_BITS-1:0] bin_level [NUM_BINS];
  bit                  bin_live  [NUM_BINS];
  bit [COUNT_BITS-1:0] peak_level;
  ghn_rsp_t            expected_reads [$];

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_histogram();
    foreach (bin_live[i]) bin_live[i] = 1'b0;
    peak_level = '0;
  endtask

  task automatic predict_request(input ghn_req_t r);
    longint unsigned level;
    longint unsigned peak;
    longint unsigned height;
    ghn_rsp_t        want;
    case (r.op)
      OP_CLEAR: clear_histogram();
      OP_COUNT: begin
        if (r.pixel_value < NUM_BINS) begin
          level = bin_live[r.pixel_value] ? bin_level[r.pixel_value] : 0;
          if (level < COUNT_FULL) level++;
          else full_bin_hits++;
          bin_level[r.pixel_value] = level[COUNT_BITS-1:0];
          bin_live[r.pixel_value]  = 1'b1;
          if (level > peak_level) peak_level = level[COUNT_BITS-1:0];
        end
      end
      OP_READ: begin
        level = 0;
        if (r.bin_index < NUM_BINS && bin_live[r.bin_index]) level = bin_level[r.bin_index];
        peak   = peak_level;
        height = (peak != 0) ? (level * HEIGHT_SCALE) / peak : 0;
        want.bin_count  = level[OUT_W-1:0];
        want.peak_count = peak[OUT_W-1:0];
        want.bar_height = height[HEIGHT_W-1:0];
        expected_reads.push_back(want);
      end
      default: ;
    endcase
  endtask

  task automatic check_response(input ghn_rsp_t got);
    ghn_rsp_t want;
    if (expected_reads.size() == 0) begin
      report_mismatch($sformatf("response with no read outstanding (bin_count %0d)",
                                got.bin_count));
      return;
    end
    want = expected_reads.pop_front();
    reads_checked++;
    if (got.bin_count !== want.bin_count)
      report_mismatch($sformatf("bin_count expected %0d got %0d",
                                want.bin_count, got.bin_count));
    if (got.peak_count !== want.peak_count)
      report_mismatch($sformatf("peak_count expected %0d got %0d",
                                want.peak_count, got.peak_count));
    if (got.bar_height !== want.bar_height)
      report_mismatch($sformatf("bar_height expected %0d got %0d",
                                want.bar_height, got.bar_height));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_histogram();
      expected_reads.delete();
    end else begin
      if (rsp.valid && rsp.ready) check_response(rsp.data);
      if (req.valid && req.ready) predict_request(req.data);
    end
    reads_pending <= expected_reads.size();
  end

endmodule

>>> tb/gray_histogram_normalizer_top_tb.sv
// ----------------------------------------------------------------------------
// gray_histogram_normalizer_top_tb
// Drives clear, count, read and unused-op requests into the histogram engine
// with random gaps on both channels and one long response hold-off, and lets
// the checker compare every read response against its own histogram.
// ----------------------------------------------------------------------------
module gray_histogram_normalizer_top_tb import ghn_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NUM_BINS     = 256;
  localparam int          COUNT_BITS   = 24;
  localparam int          TOTAL_ITEMS  = 1100;
  localparam int          HOLD_AT      = 300;
  localparam int          LONG_HOLD    = 300;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int unsigned cycles;
  int unsigned n_clear, n_count, n_read, n_unused;
  int unsigned mismatches, reads_checked, full_bin_hits, reads_pending;
  bit          send_calm, take_calm, hold_request, hold_done;

  ghn_req_if req_ch ();
  ghn_rsp_if rsp_ch ();

  always #1 clk = ~clk;

  gray_histogram_normalizer_top #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  gray_histogram_normalizer_checker #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .mismatches    (mismatches),
    .reads_checked (reads_checked),
    .full_bin_hits (full_bin_hits),
    .reads_pending (reads_pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[%0t] timeout with %0d reads outstanding", $time, reads_pending);
      $display("gray_histogram_normalizer_top_tb NOT OK");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [7:0] pix, input logic [7:0] idx);
    int unsigned gap;
    if ($urandom_range(0, 99) < 4) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= '{op: op, pixel_value: pix, bin_index: idx};
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    case (op)
      OP_CLEAR: n_clear++;
      OP_COUNT: n_count++;
      OP_READ:  n_read++;
      default:  n_unused++;
    endcase
  endtask

  function automatic logic [7:0] pick_level(input int unsigned hot_pct, input logic [7:0] hot);
    return ($urandom_range(0, 99) < hot_pct) ? hot : 8'($urandom_range(0, 255));
  endfunction

  // response side: random stalls, calm stretches and one long hold-off
  initial begin
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end
      if ($urandom_range(0, 99) < 4) take_calm = !take_calm;
      stall = take_calm ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  initial begin
    int unsigned frame_len, hot_pct, read_pct, roll;
    logic [7:0]  hot;
    bit          long_frame;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_READ,   8'hFF, 8'h00);
    send_request(OP_COUNT,  8'h00, 8'hFF);
    send_request(OP_COUNT,  8'hFF, 8'h00);
    send_request(OP_COUNT,  8'h80, 8'h00);
    send_request(OP_COUNT,  8'h80, 8'hFF);
    send_request(OP_COUNT,  8'(NUM_BINS - 1), 8'h00);
    send_request(OP_READ,   8'h00, 8'h00);
    send_request(OP_READ,   8'hFF, 8'h80);
    send_request(OP_READ,   8'h00, 8'hFF);
    send_request(OP_READ,   8'h00, 8'(NUM_BINS - 1));
    send_request(OP_READ,   8'h00, 8'h05);
    send_request(OP_UNUSED, 8'h80, 8'h80);
    send_request(OP_READ,   8'h00, 8'h80);
    send_request(OP_CLEAR,  8'hFF, 8'hFF);
    send_request(OP_READ,   8'h00, 8'h80);
    send_request(OP_READ,   8'hFF, 8'h00);
    send_request(OP_COUNT,  8'h80, 8'h00);
    send_request(OP_READ,   8'h00, 8'h80);
    send_request(OP_READ,   8'h00, 8'h00);
    send_request(OP_UNUSED, 8'h00, 8'h00);

    long_frame = 1'b1;
    while (n_clear + n_count + n_read < TOTAL_ITEMS) begin
      if (long_frame) begin
        frame_len = 450;
        hot       = 8'($urandom_range(0, NUM_BINS - 1));
        hot_pct   = 85;
        read_pct  = 10;
      end else begin
        frame_len = $urandom_range(8, 80);
        hot       = 8'($urandom_range(0, 255));
        hot_pct   = $urandom_range(0, 90);
        read_pct  = $urandom_range(5, 40);
      end
      long_frame = 1'b0;
      if ($urandom_range(0, 3) != 0)
        send_request(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      for (int i = 0; i < frame_len; i++) begin
        if (!hold_done && n_clear + n_count + n_read >= HOLD_AT) begin
          hold_request = 1'b1;
          hold_done    = 1'b1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
          send_request(OP_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        else if (roll < 4 + read_pct)
          send_request(OP_READ, 8'($urandom_range(0, 255)), pick_level(hot_pct, hot));
        else
          send_request(OP_COUNT, pick_level(hot_pct, hot), 8'($urandom_range(0, 255)));
      end
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (reads_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d clears, %0d pixel counts, %0d bin reads, %0d unused-op requests.",
             n_clear, n_count, n_read, n_unused);
    $display("Checked %0d read responses; %0d counts hit a full bin; %0d mismatches.",
             reads_checked, full_bin_hits, mismatches);
    if (mismatches == 0) begin
      $display("gray_histogram_normalizer_top_tb OK");
    end else begin
      $display("gray_histogram_normalizer_top_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> gray_histogram_normalizer_top.f
rtl/ghn_pkg.sv
rtl/ghn_req_if.sv
rtl/ghn_rsp_if.sv
rtl/ghn_bin_ram.sv
rtl/ghn_divider.sv
rtl/gray_histogram_normalizer_top.sv
rtl/ghn_checker.sv
tb/gray_histogram_normalizer_checker.sv
tb/gray_histogram_normalizer_top_tb.sv
